// ===== rtl/core/stpe_pkg.sv =====
`timescale 1ns / 1ps
package stpe_pkg;

  // Width of the side-length configuration register.
  localparam int SIDE_BITS = 4;

  // Action codes carried by a request.
  typedef enum logic [2:0] {
    ACT_WRITE  = 3'd0,
    ACT_READ   = 3'd1,
    ACT_ORIENT = 3'd2,
    ACT_RING   = 3'd3,
    ACT_MAP2   = 3'd4,
    ACT_MAP4   = 3'd5,
    ACT_ORBIT  = 3'd6
  } act_t;

  // Reorient kinds.
  localparam logic [2:0] ORI_ROT90  = 3'd0;
  localparam logic [2:0] ORI_ROT270 = 3'd1;
  localparam logic [2:0] ORI_ROT180 = 3'd2;
  localparam logic [2:0] ORI_MIRC   = 3'd3;
  localparam logic [2:0] ORI_MIRR   = 3'd4;
  localparam logic [2:0] ORI_TRANS  = 3'd5;
  localparam logic [2:0] ORI_ATRANS = 3'd6;

  // Controller states: result register empty or holding a result.
  typedef enum logic {
    ST_EMPTY = 1'b0,
    ST_FULL  = 1'b1
  } ctl_state_t;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic exec;
  } ctl_cmd_t;

endpackage

// ===== rtl/core/square_tile_permute_engine.sv =====
`timescale 1ns / 1ps
// The result of a request is registered and presented in the cycle after it is accepted.
// Throughput: one request per cycle unless a held result is stalled; each operation is a
// single pass through the per-cell source multiplexers in front of the register tile.
// Reset (synchronous, active low) sets the side to 8 (or the tile size if smaller),
// loads every cell with row*side + column and marks the result register empty.
module square_tile_permute_engine #(
  parameter int MAX_SIDE  = 8,
  parameter int CELL_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [stpe_pkg::SIDE_BITS-1:0] cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [2:0]                     in_action,
  input  logic [2:0]                     in_col,
  input  logic [2:0]                     in_row,
  input  logic [7:0]                     in_value,
  input  logic [2:0]                     in_variant,
  input  logic                           in_hand,
  input  logic [63:0]                    in_block_map,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_read_value,
  output logic                           out_bad_request
);
  import stpe_pkg::*;

  ctl_cmd_t cmd;

  // Handshake control.
  stpe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Tile, side register and result register.
  stpe_datapath #(
    .MAX_SIDE  (MAX_SIDE),
    .CELL_BITS (CELL_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_action       (in_action),
    .in_col          (in_col),
    .in_row          (in_row),
    .in_value        (in_value),
    .in_variant      (in_variant),
    .in_hand         (in_hand),
    .in_block_map    (in_block_map),
    .out_read_value  (out_read_value),
    .out_bad_request (out_bad_request)
  );

endmodule

// ===== rtl/core/stpe_ctrl.sv =====
`timescale 1ns / 1ps
module stpe_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output stpe_pkg::ctl_cmd_t cmd
);
  import stpe_pkg::*;

  ctl_state_t state_r, state_nxt;

  // Output decode: a request is taken unless a held result is blocked.
  always_comb begin
    out_valid = (state_r == ST_FULL);
    in_stall  = (state_r == ST_FULL) && out_stall;
    cmd.exec  = in_valid && !in_stall;
  end

  // Next state: a new request refills the result register; an unstalled held result empties it.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_EMPTY: begin
        if (cmd.exec) state_nxt = ST_FULL;
      end
      ST_FULL: begin
        if (cmd.exec) state_nxt = ST_FULL;
        else if (!out_stall) state_nxt = ST_EMPTY;
      end
      default: state_nxt = ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_EMPTY;
    else state_r <= state_nxt;
  end

endmodule

// ===== rtl/core/stpe_datapath.sv =====
`timescale 1ns / 1ps
module stpe_datapath #(
  parameter int MAX_SIDE  = 8,
  parameter int CELL_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  stpe_pkg::ctl_cmd_t             cmd,
  input  logic                           cfg_wr_en,
  input  logic [stpe_pkg::SIDE_BITS-1:0] cfg_wr_data,
  input  logic [2:0]                     in_action,
  input  logic [2:0]                     in_col,
  input  logic [2:0]                     in_row,
  input  logic [7:0]                     in_value,
  input  logic [2:0]                     in_variant,
  input  logic                           in_hand,
  input  logic [63:0]                    in_block_map,
  output logic [7:0]                     out_read_value,
  output logic                           out_bad_request
);
  import stpe_pkg::*;

  localparam int CELLS    = MAX_SIDE * MAX_SIDE;
  localparam int CW       = $clog2(MAX_SIDE);
  localparam int NW       = $clog2(MAX_SIDE + 1);
  localparam int IW       = $clog2(CELLS);
  localparam int TW       = NW + 2;
  localparam int RST_SIDE = (8 < MAX_SIDE) ? 8 : MAX_SIDE;

  logic [SIDE_BITS-1:0] tile_side_r;
  logic [CELL_BITS-1:0] tile_r   [CELLS];
  logic [CELL_BITS-1:0] tile_nxt [CELLS];
  logic [7:0]           read_value_r;
  logic                 bad_r;

  logic [NW-1:0] n;
  logic [CW-1:0] nm1;
  logic [CW-1:0] colc, rowc;
  logic          in_bounds;
  logic          bad;
  logic          per4;
  logic [NW-1:0] blk;
  logic [TW-1:0] thr [5];
  logic [CW-1:0] qc [4];
  logic [CW-1:0] qr [4];
  logic [IW-1:0] rd_idx;

  // Active side, capped at the tile size.
  always_comb begin
    if ({1'b0, tile_side_r} > (SIDE_BITS + 1)'(MAX_SIDE)) n = NW'(MAX_SIDE);
    else n = NW'(tile_side_r);
    nm1       = CW'(n - NW'(1));
    colc      = CW'(in_col);
    rowc      = CW'(in_row);
    in_bounds = (in_col < n) && (in_row < n);
    rd_idx    = IW'(IW'(rowc) * IW'(MAX_SIDE) + IW'(colc));
  end

  // Request checking.
  always_comb begin
    bad = 1'b0;
    case (act_t'(in_action))
      ACT_WRITE:  bad = !in_bounds;
      ACT_READ:   bad = !in_bounds;
      ACT_ORIENT: bad = (in_variant == 3'd7);
      ACT_RING:   bad = (in_variant > 3'd1);
      ACT_MAP2:   bad = 1'b0;
      ACT_MAP4:   bad = 1'b0;
      ACT_ORBIT:  bad = !in_bounds || (in_variant == 3'd0) || (in_variant > 3'd3);
      default:    bad = 1'b1;
    endcase
    if (n == NW'(0)) bad = 1'b1;
  end

  // Block size and block boundaries for the block maps.
  always_comb begin
    per4 = (act_t'(in_action) == ACT_MAP4);
    blk  = per4 ? (n >> 2) : (n >> 1);
    for (int k = 0; k < 5; k++) begin
      thr[k] = TW'(TW'(blk) * TW'(k));
    end
  end

  // Four cells of the rotation orbit through the start cell.
  always_comb begin
    qc[0] = colc;
    qr[0] = rowc;
    for (int i = 0; i < 3; i++) begin
      if (in_hand) begin
        qc[i + 1] = qr[i];
        qr[i + 1] = nm1 - qc[i];
      end else begin
        qc[i + 1] = nm1 - qr[i];
        qr[i + 1] = qc[i];
      end
    end
  end

  // Per-cell source selection.
  for (genvar gy = 0; gy < MAX_SIDE; gy++) begin : g_row
    for (genvar gx = 0; gx < MAX_SIDE; gx++) begin : g_col
      localparam int            IDX = gy * MAX_SIDE + gx;
      localparam logic [CW-1:0] CX  = CW'(gx);
      localparam logic [CW-1:0] CY  = CW'(gy);

      logic          active;
      logic          in_reg;
      logic [1:0]    dbx, dby, sbx, sby;
      logic [3:0]    e4;
      logic [1:0]    e2;
      logic [CW-1:0] bx, by;
      logic [CW-1:0] dx, dy, m1, m2, rmin;
      logic [CW-1:0] sx, sy;
      logic          move;
      logic [IW-1:0] src_idx;

      // Block position of this cell and its source block.
      always_comb begin
        in_reg = per4 ? ((TW'(CX) < thr[4]) && (TW'(CY) < thr[4]))
                      : ((TW'(CX) < thr[2]) && (TW'(CY) < thr[2]));
        dbx = 2'(TW'(CX) >= thr[1]) + 2'(TW'(CX) >= thr[2]) + 2'(TW'(CX) >= thr[3]);
        dby = 2'(TW'(CY) >= thr[1]) + 2'(TW'(CY) >= thr[2]) + 2'(TW'(CY) >= thr[3]);
        bx  = CW'(TW'(CX) - thr[dbx]);
        by  = CW'(TW'(CY) - thr[dby]);
        e4  = in_block_map[{dby, dbx, 2'b00} +: 4];
        e2  = in_block_map[{dby[0], dbx[0], 1'b0} +: 2];
        sbx = per4 ? e4[1:0] : {1'b0, e2[0]};
        sby = per4 ? e4[3:2] : {1'b0, e2[1]};
      end

      // Ring index parity from the distance to the nearest edge.
      always_comb begin
        dx   = nm1 - CX;
        dy   = nm1 - CY;
        m1   = (CX < CY) ? CX : CY;
        m2   = (dx < dy) ? dx : dy;
        rmin = (m1 < m2) ? m1 : m2;
      end

      // Source coordinate for the requested action.
      always_comb begin
        active = (gx < n) && (gy < n);
        sx     = CX;
        sy     = CY;
        move   = 1'b0;
        case (act_t'(in_action))
          ACT_ORIENT: begin
            move = 1'b1;
            case (in_variant)
              ORI_ROT90:  begin sx = CY;  sy = dx;  end
              ORI_ROT270: begin sx = dy;  sy = CX;  end
              ORI_ROT180: begin sx = dx;  sy = dy;  end
              ORI_MIRC:   begin sx = dx;  sy = CY;  end
              ORI_MIRR:   begin sx = CX;  sy = dy;  end
              ORI_TRANS:  begin sx = CY;  sy = CX;  end
              ORI_ATRANS: begin sx = dy;  sy = dx;  end
              default:    move = 1'b0;
            endcase
          end
          ACT_RING: begin
            move = 1'b1;
            // Even rings turn in the requested direction, odd rings the other way.
            if (rmin[0] == in_variant[0]) begin
              sx = CY;
              sy = dx;
            end else begin
              sx = dy;
              sy = CX;
            end
          end
          ACT_MAP2, ACT_MAP4: begin
            move = in_reg;
            sx   = CW'(thr[sbx] + TW'(bx));
            sy   = CW'(thr[sby] + TW'(by));
          end
          ACT_ORBIT: begin
            for (int i = 0; i < 4; i++) begin
              if ((CX == qc[i]) && (CY == qr[i])) begin
                move = 1'b1;
                sx   = qc[2'(i - int'(in_variant[1:0]))];
                sy   = qr[2'(i - int'(in_variant[1:0]))];
              end
            end
          end
          default: move = 1'b0;
        endcase
        src_idx = IW'(IW'(sy) * IW'(MAX_SIDE) + IW'(sx));
      end

      // Next cell value.
      always_comb begin
        tile_nxt[IDX] = tile_r[IDX];
        if (cmd.exec && !bad && active) begin
          if (act_t'(in_action) == ACT_WRITE) begin
            if ((CX == colc) && (CY == rowc)) tile_nxt[IDX] = CELL_BITS'(in_value);
          end else if (move) begin
            tile_nxt[IDX] = tile_r[src_idx];
          end
        end
      end
    end
  end

  // Tile storage; reset loads the row-major ramp.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CELLS; i++) begin
        tile_r[i] <= CELL_BITS'((i / MAX_SIDE) * RST_SIDE + (i % MAX_SIDE));
      end
    end else begin
      for (int i = 0; i < CELLS; i++) begin
        tile_r[i] <= tile_nxt[i];
      end
    end
  end

  // Side register.
  always_ff @(posedge clk) begin
    if (!rst_n) tile_side_r <= SIDE_BITS'(RST_SIDE);
    else if (cfg_wr_en) tile_side_r <= cfg_wr_data;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      bad_r <= bad;
      if (!bad && act_t'(in_action) == ACT_READ) read_value_r <= 8'(tile_r[rd_idx]);
      else read_value_r <= 8'd0;
    end
  end

  assign out_read_value  = read_value_r;
  assign out_bad_request = bad_r;

endmodule
